>>> sv/pmatc_pkg.sv
// Package for the parallel-machine ATC dispatch unit.
// Holds command codes, fixed field widths and the exp step table; no dependencies.
`default_nettype none
package pmatc_pkg;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 5;
   localparam int WGT_W   = 8;
   localparam int TIME_W  = 16;
   localparam int MACH_W  = 3;
   localparam int START_W = 24;
   localparam int TARD_W  = 40;
   localparam int TOTAL_W = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int XQ_W    = 13;
   localparam int XQ_CLIP = 4096;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_LOAD_JOB = 2'd0;
   localparam cmd_type CMD_LOAD_DUE = 2'd1;
   localparam cmd_type CMD_RUN      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_JOB_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MACH_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOK_AHEAD = 2'd2;

   // round(65536 * exp(-2^i / 256))
   function automatic logic [15:0] exp_step(input logic [3:0] idx);
      logic [15:0] c;
      case (idx)
         4'd0:    c = 16'd65280;
         4'd1:    c = 16'd65026;
         4'd2:    c = 16'd64520;
         4'd3:    c = 16'd63520;
         4'd4:    c = 16'd61565;
         4'd5:    c = 16'd57835;
         4'd6:    c = 16'd51039;
         4'd7:    c = 16'd39750;
         4'd8:    c = 16'd24109;
         4'd9:    c = 16'd8869;
         4'd10:   c = 16'd1200;
         4'd11:   c = 16'd22;
         default: c = 16'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> sv/pmatc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pmatc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> sv/parallel_machine_atc_dispatch_unit.sv
// Parallel-machine ATC dispatch unit: top level, sequencer and shared datapath.
// Depends on pmatc_pkg and pmatc_ram.
//
// Usage:
//  req channel (req_valid/req_stall): cmd 0 loads a job's weight, release and
//  processing time, cmd 1 loads one due entry, cmd 2 runs a dispatch. A run
//  emits one rsp beat per job, in dispatch order, the final one with rsp_last
//  set.
//  csr port: csr_wr_en, csr_index, csr_wdata write job_count, machine_count
//  and look_ahead_scale; write only while the unit is idle.
//  A run first sums the processing times. Each dispatch step then scans the
//  machines and every open job against every due entry; an entry may pass
//  through the shared divider (12 steps) and the exp multiplier (13 steps).
//  req_stall is high for the whole run.
//  Reset: synchronous; afterwards a clearing pass of MAX_JOBS^2 entries
//  (rounded up to a power of two, 1024 by default) marks all due entries
//  absent while req_stall is held high.
//  A stalled rsp beat is held; the next step is computed meanwhile and waits
//  until the output register frees up.
`default_nettype none
module parallel_machine_atc_dispatch_unit #(
   parameter int MAX_JOBS     = 32,
   parameter int MAX_MACHINES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pmatc_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [pmatc_pkg::ID_W-1:0]         req_job_id,
   input  wire logic [pmatc_pkg::ID_W-1:0]         req_due_slot,
   input  wire logic [pmatc_pkg::WGT_W-1:0]        req_weight,
   input  wire logic [pmatc_pkg::TIME_W-1:0]       req_release_time,
   input  wire logic [pmatc_pkg::TIME_W-1:0]       req_process_time,
   input  wire logic [pmatc_pkg::TIME_W-1:0]       req_due_time,
   input  wire logic                               req_due_present,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [pmatc_pkg::MACH_W-1:0]            rsp_machine_id,
   output logic [pmatc_pkg::ID_W-1:0]              rsp_job_id_out,
   output logic [pmatc_pkg::START_W-1:0]           rsp_start_time,
   output logic [pmatc_pkg::TARD_W-1:0]            rsp_job_tardiness,
   output logic [pmatc_pkg::TOTAL_W-1:0]           rsp_total_tardiness,
   output logic                                    rsp_last,
   input  wire logic                               csr_wr_en,
   input  wire logic [pmatc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pmatc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pmatc_pkg::*;

   localparam int JW    = $clog2(MAX_JOBS);
   localparam int CW    = $clog2(MAX_JOBS + 1);
   localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int MCW   = $clog2(MAX_MACHINES + 1);
   localparam int DAW   = 2 * JW;
   localparam int SUMW  = TIME_W + JW;
   localparam int DENW  = 8 + SUMW;
   localparam int NUMW  = 17 + CW + 12;
   localparam int CMPW  = DENW + 12;
   localparam int AW    = 24 + JW;
   localparam int PW    = AW + TIME_W;
   localparam int LW    = 25 + JW;
   localparam int TW    = LW + WGT_W;
   localparam int JOBW  = WGT_W + 2 * TIME_W;

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_SUM     = 5'd2;
   localparam logic [4:0] S_SUM_ACC = 5'd3;
   localparam logic [4:0] S_DEN     = 5'd4;
   localparam logic [4:0] S_MSEL    = 5'd5;
   localparam logic [4:0] S_JSEL    = 5'd6;
   localparam logic [4:0] S_JLOAD   = 5'd7;
   localparam logic [4:0] S_KRD     = 5'd8;
   localparam logic [4:0] S_KDATA   = 5'd9;
   localparam logic [4:0] S_NUM     = 5'd10;
   localparam logic [4:0] S_CLIP    = 5'd11;
   localparam logic [4:0] S_DIV     = 5'd12;
   localparam logic [4:0] S_EXP     = 5'd13;
   localparam logic [4:0] S_ACC     = 5'd14;
   localparam logic [4:0] S_CMP1    = 5'd15;
   localparam logic [4:0] S_CMP2    = 5'd16;
   localparam logic [4:0] S_CMP3    = 5'd17;
   localparam logic [4:0] S_FIN_RD  = 5'd18;
   localparam logic [4:0] S_FIN     = 5'd19;
   localparam logic [4:0] S_LRD     = 5'd20;
   localparam logic [4:0] S_LACC    = 5'd21;
   localparam logic [4:0] S_TARD    = 5'd22;
   localparam logic [4:0] S_OUT     = 5'd23;

   logic [4:0]        state_ff, state_in;
   logic [DAW-1:0]    clr_ff, clr_in;
   logic [5:0]        jc_ff, jc_in;
   logic [3:0]        mc_ff, mc_in;
   logic [7:0]        las_ff, las_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [MCW-1:0]    m_ff, m_in;
   logic [SUMW-1:0]   sum_ff, sum_in;
   logic [DENW-1:0]   den_ff, den_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [MW-1:0]     mach_ff, mach_in;
   logic [MCW-1:0]    mi_ff, mi_in;
   logic [23:0]       t_ff, t_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     k_ff, k_in;
   logic              have_ff, have_in;
   logic [JW-1:0]     best_ff, best_in;
   logic [AW-1:0]     besta_ff, besta_in;
   logic [15:0]       bestp_ff, bestp_in;
   logic [15:0]       pj_ff, pj_in;
   logic [15:0]       rj_ff, rj_in;
   logic [AW-1:0]     a_ff, a_in;
   logic [16:0]       slack_ff, slack_in;
   logic [7:0]        wk_ff, wk_in;
   logic [NUMW-1:0]   rem_ff, rem_in;
   logic [XQ_W-1:0]   xq_ff, xq_in;
   logic [3:0]        bit_ff, bit_in;
   logic [16:0]       e_ff, e_in;
   logic [3:0]        ei_ff, ei_in;
   logic [PW-1:0]     lhs_ff, lhs_in;
   logic [PW-1:0]     rhs_ff, rhs_in;
   logic [23:0]       start_ff, start_in;
   logic [24:0]       fin_ff, fin_in;
   logic [7:0]        wb_ff, wb_in;
   logic [LW-1:0]     late_ff, late_in;
   logic [TW-1:0]     tard_ff, tard_in;
   logic              done_ff [MAX_JOBS];
   logic              done_in [MAX_JOBS];
   logic [23:0]       mft_ff [MAX_MACHINES];
   logic [23:0]       mft_in [MAX_MACHINES];
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MACH_W-1:0] rsp_mach_ff, rsp_mach_in;
   logic [ID_W-1:0]   rsp_job_ff, rsp_job_in;
   logic [23:0]       rsp_start_ff, rsp_start_in;
   logic [TARD_W-1:0] rsp_tard_ff, rsp_tard_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_acc;
   logic              job_we, due_we;
   logic [JW-1:0]     job_wa, ja_addr;
   logic [JOBW-1:0]   job_wd, ja_data, jb_data;
   logic [DAW-1:0]    due_wa, due_ra;
   logic [16:0]       due_wd, due_data;
   logic [15:0]       p_store;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;

   assign p_store = (req_process_time == '0) ? 16'd1 : req_process_time;
   assign job_we  = req_acc && (req_cmd == CMD_LOAD_JOB) && (32'(req_job_id) < MAX_JOBS);
   assign job_wa  = JW'(req_job_id);
   assign job_wd  = {req_weight, req_release_time, p_store};
   assign ja_addr = (state_ff == S_FIN_RD) ? best_ff : j_ff[JW-1:0];

   assign due_we = (state_ff == S_CLEAR) ||
                   (req_acc && (req_cmd == CMD_LOAD_DUE) &&
                    (32'(req_job_id) < MAX_JOBS) && (32'(req_due_slot) < MAX_JOBS));
   assign due_wa = (state_ff == S_CLEAR) ? clr_ff :
                   {JW'(req_job_id), JW'(req_due_slot)};
   assign due_wd = (state_ff == S_CLEAR) ? 17'd0 : {req_due_present, req_due_time};
   assign due_ra = {((state_ff == S_LRD) ? best_ff : j_ff[JW-1:0]), k_ff[JW-1:0]};

   pmatc_ram #(.WIDTH(JOBW), .DEPTH(MAX_JOBS)) u_job_a (
      .clock(clock), .wr_en(job_we), .wr_addr(job_wa), .wr_data(job_wd),
      .rd_addr(ja_addr), .rd_data(ja_data)
   );

   pmatc_ram #(.WIDTH(JOBW), .DEPTH(MAX_JOBS)) u_job_b (
      .clock(clock), .wr_en(job_we), .wr_addr(job_wa), .wr_data(job_wd),
      .rd_addr(k_ff[JW-1:0]), .rd_data(jb_data)
   );

   pmatc_ram #(.WIDTH(17), .DEPTH(1 << DAW)) u_due (
      .clock(clock), .wr_en(due_we), .wr_addr(due_wa), .wr_data(due_wd),
      .rd_addr(due_ra), .rd_data(due_data)
   );

   always_comb begin
      logic [16:0]     pos;
      logic [24:0]     neg;
      logic [NUMW-1:0] num;
      logic [CMPW-1:0] dsh;
      logic [33:0]     ep;
      logic [15:0]     e16;
      logic [15:0]     rb;
      logic [24:0]     fin;
      logic [TOTAL_W:0] tsum;
      logic [SUMW-1:0] sum1;
      logic [7:0]      k1;

      state_in = state_ff;  clr_in = clr_ff;
      jc_in = jc_ff;  mc_in = mc_ff;  las_in = las_ff;
      n_in = n_ff;  m_in = m_ff;  sum_in = sum_ff;  den_in = den_ff;
      step_in = step_ff;  mach_in = mach_ff;  mi_in = mi_ff;  t_in = t_ff;
      j_in = j_ff;  k_in = k_ff;  have_in = have_ff;  best_in = best_ff;
      besta_in = besta_ff;  bestp_in = bestp_ff;  pj_in = pj_ff;  rj_in = rj_ff;
      a_in = a_ff;  slack_in = slack_ff;  wk_in = wk_ff;  rem_in = rem_ff;
      xq_in = xq_ff;  bit_in = bit_ff;  e_in = e_ff;  ei_in = ei_ff;
      lhs_in = lhs_ff;  rhs_in = rhs_ff;  start_in = start_ff;  fin_in = fin_ff;
      wb_in = wb_ff;  late_in = late_ff;  tard_in = tard_ff;
      done_in = done_ff;  mft_in = mft_ff;  total_in = total_ff;
      rsp_mach_in = rsp_mach_ff;  rsp_job_in = rsp_job_ff;
      rsp_start_in = rsp_start_ff;  rsp_tard_in = rsp_tard_ff;
      rsp_total_in = rsp_total_ff;  rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      pos  = 17'(rj_ff) + 17'(due_data[15:0]);
      neg  = 25'(pj_ff) + 25'(t_ff);
      num  = NUMW'(slack_ff) * (NUMW'(n_ff) << 12);
      dsh  = CMPW'(den_ff) << bit_ff;
      ep   = 34'(e_ff) * 34'(exp_step(ei_ff)) + 34'd32768;
      e16  = (e_ff > 17'd65535) ? 16'hFFFF : e_ff[15:0];
      rb   = ja_data[31:16];
      fin  = 25'((rb > t_ff[15:0] && t_ff[23:16] == '0) ? 24'(rb) : t_ff) +
             25'(ja_data[15:0]);
      tsum = (TOTAL_W + 1)'(total_ff) + (TOTAL_W + 1)'(tard_ff);
      sum1 = (sum_ff == '0) ? SUMW'(1) : sum_ff;
      k1   = (las_ff == '0) ? 8'd1 : las_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_JOB_COUNT:  jc_in  = csr_wdata[5:0];
            CSR_MACH_COUNT: mc_in  = csr_wdata[3:0];
            CSR_LOOK_AHEAD: las_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_acc && req_cmd == CMD_RUN) begin
               n_in = (jc_ff == '0) ? CW'(1) :
                      ((32'(jc_ff) > MAX_JOBS) ? CW'(MAX_JOBS) : CW'(jc_ff));
               m_in = (mc_ff == '0) ? MCW'(1) :
                      ((32'(mc_ff) > MAX_MACHINES) ? MCW'(MAX_MACHINES) : MCW'(mc_ff));
               sum_in   = '0;
               j_in     = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: state_in = S_SUM_ACC;
         S_SUM_ACC: begin
            sum_in = sum_ff + SUMW'(ja_data[15:0]);
            j_in   = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == n_ff) ? S_DEN : S_SUM;
         end
         S_DEN: begin
            den_in = DENW'(k1) * DENW'(sum1);
            for (int i = 0; i < MAX_JOBS; i++) done_in[i] = 1'b0;
            for (int i = 0; i < MAX_MACHINES; i++) mft_in[i] = '0;
            total_in = '0;
            step_in  = '0;
            mach_in  = '0;
            mi_in    = MCW'(1);
            state_in = S_MSEL;
         end
         S_MSEL: begin
            if (mi_ff < m_ff) begin
               if (mft_ff[mi_ff[MW-1:0]] < mft_ff[mach_ff]) mach_in = mi_ff[MW-1:0];
               mi_in = mi_ff + 1'b1;
            end else begin
               t_in     = mft_ff[mach_ff];
               j_in     = '0;
               have_in  = 1'b0;
               state_in = S_JSEL;
            end
         end
         S_JSEL: begin
            if (j_ff == n_ff) begin
               state_in = S_FIN_RD;
            end else if (done_ff[j_ff[JW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_JLOAD;
            end
         end
         S_JLOAD: begin
            pj_in    = ja_data[15:0];
            rj_in    = ja_data[31:16];
            a_in     = '0;
            k_in     = '0;
            state_in = S_KRD;
         end
         S_KRD: state_in = (k_ff == n_ff) ? S_CMP1 : S_KDATA;
         S_KDATA: begin
            wk_in = jb_data[39:32];
            xq_in = '0;
            if (!due_data[16]) begin
               k_in     = k_ff + 1'b1;
               state_in = S_KRD;
            end else if (25'(pos) > neg) begin
               slack_in = 17'(25'(pos) - neg);
               state_in = S_NUM;
            end else begin
               e_in     = 17'd65536;
               ei_in    = '0;
               state_in = S_EXP;
            end
         end
         S_NUM: begin
            rem_in   = num;
            state_in = S_CLIP;
         end
         S_CLIP: begin
            bit_in = 4'd11;
            e_in   = 17'd65536;
            ei_in  = '0;
            if (CMPW'(rem_ff) >= (CMPW'(den_ff) << 12)) begin
               xq_in    = XQ_W'(XQ_CLIP);
               state_in = S_EXP;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (CMPW'(rem_ff) >= dsh) begin
               rem_in        = NUMW'(CMPW'(rem_ff) - dsh);
               xq_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) state_in = S_EXP;
         end
         S_EXP: begin
            if (xq_ff[ei_ff]) e_in = ep[32:16];
            ei_in = ei_ff + 1'b1;
            if (ei_ff == 4'(XQ_W - 1)) state_in = S_ACC;
         end
         S_ACC: begin
            a_in     = a_ff + AW'(24'(wk_ff) * 24'(e16));
            k_in     = k_ff + 1'b1;
            state_in = S_KRD;
         end
         S_CMP1: begin
            lhs_in   = PW'(a_ff) * PW'(bestp_ff);
            state_in = S_CMP2;
         end
         S_CMP2: begin
            rhs_in   = PW'(besta_ff) * PW'(pj_ff);
            state_in = S_CMP3;
         end
         S_CMP3: begin
            if (!have_ff || lhs_ff > rhs_ff) begin
               have_in  = 1'b1;
               best_in  = j_ff[JW-1:0];
               besta_in = a_ff;
               bestp_in = pj_ff;
            end
            j_in     = j_ff + 1'b1;
            state_in = S_JSEL;
         end
         S_FIN_RD: state_in = S_FIN;
         S_FIN: begin
            start_in = (24'(rb) > t_ff) ? 24'(rb) : t_ff;
            fin_in   = fin;
            wb_in    = ja_data[39:32];
            late_in  = '0;
            k_in     = '0;
            state_in = S_LRD;
         end
         S_LRD: state_in = (k_ff == n_ff) ? S_TARD : S_LACC;
         S_LACC: begin
            if (due_data[16] && fin_ff > 25'(due_data[15:0]))
               late_in = late_ff + LW'(fin_ff - 25'(due_data[15:0]));
            k_in     = k_ff + 1'b1;
            state_in = S_LRD;
         end
         S_TARD: begin
            tard_in  = TW'(late_ff) * TW'(wb_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               total_in = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
               done_in[best_ff] = 1'b1;
               mft_in[mach_ff]  = fin_ff[24] ? 24'hFFFFFF : fin_ff[23:0];
               rsp_valid_in = 1'b1;
               rsp_mach_in  = MACH_W'(mach_ff);
               rsp_job_in   = ID_W'(best_ff);
               rsp_start_in = start_ff;
               rsp_tard_in  = TARD_W'(tard_ff);
               rsp_total_in = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
               rsp_last_in  = (step_ff + 1'b1 == n_ff);
               step_in      = step_ff + 1'b1;
               mach_in      = '0;
               mi_in        = MCW'(1);
               state_in     = (step_ff + 1'b1 == n_ff) ? S_IDLE : S_MSEL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         jc_ff        <= 6'd32;
         mc_ff        <= 4'd1;
         las_ff       <= 8'd32;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_JOBS; i++) done_ff[i] <= 1'b0;
         for (int i = 0; i < MAX_MACHINES; i++) mft_ff[i] <= '0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         jc_ff        <= jc_in;
         mc_ff        <= mc_in;
         las_ff       <= las_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         mft_ff       <= mft_in;
         total_ff     <= total_in;
      end
      n_ff <= n_in;  m_ff <= m_in;  sum_ff <= sum_in;  den_ff <= den_in;
      step_ff <= step_in;  mach_ff <= mach_in;  mi_ff <= mi_in;  t_ff <= t_in;
      j_ff <= j_in;  k_ff <= k_in;  have_ff <= have_in;  best_ff <= best_in;
      besta_ff <= besta_in;  bestp_ff <= bestp_in;  pj_ff <= pj_in;  rj_ff <= rj_in;
      a_ff <= a_in;  slack_ff <= slack_in;  wk_ff <= wk_in;  rem_ff <= rem_in;
      xq_ff <= xq_in;  bit_ff <= bit_in;  e_ff <= e_in;  ei_ff <= ei_in;
      lhs_ff <= lhs_in;  rhs_ff <= rhs_in;  start_ff <= start_in;  fin_ff <= fin_in;
      wb_ff <= wb_in;  late_ff <= late_in;  tard_ff <= tard_in;
      rsp_mach_ff <= rsp_mach_in;  rsp_job_ff <= rsp_job_in;
      rsp_start_ff <= rsp_start_in;  rsp_tard_ff <= rsp_tard_in;
      rsp_total_ff <= rsp_total_in;  rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_machine_id      = rsp_mach_ff;
   assign rsp_job_id_out      = rsp_job_ff;
   assign rsp_start_time      = rsp_start_ff;
   assign rsp_job_tardiness   = rsp_tard_ff;
   assign rsp_total_tardiness = rsp_total_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for parallel_machine_atc_dispatch_unit: loads jobs and due dates,
// runs dispatches under several flow-control modes and checks every rsp beat against a
// built-in ATC predictor. Depends on pmatc_pkg and the dispatch unit RTL.
module tb;
   import pmatc_pkg::*;

   localparam int LIMIT = 20_000_000;
   localparam int SETTLE = 40;
   localparam cmd_type CMD_NOP = 2'd3;
   localparam logic [15:0] EXP_C [13] = '{16'd65280, 16'd65026, 16'd64520, 16'd63520,
      16'd61565, 16'd57835, 16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200,
      16'd22, 16'd0};

   typedef struct {
      logic [MACH_W-1:0]  mach;
      logic [ID_W-1:0]    job;
      logic [START_W-1:0] start;
      logic [TARD_W-1:0]  tard;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } dispatch_type;

   typedef struct {
      cmd_type           cmd;
      logic [ID_W-1:0]   jid;
      logic [ID_W-1:0]   slot;
      logic [WGT_W-1:0]  wgt;
      logic [TIME_W-1:0] rel;
      logic [TIME_W-1:0] proc_t;
      logic [TIME_W-1:0] due;
      logic              pres;
   } order_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      order_type             o;
      bit                    exp_on;
      dispatch_type          e;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [ID_W-1:0] req_job_id = '0, req_due_slot = '0;
   logic [WGT_W-1:0] req_weight = '0;
   logic [TIME_W-1:0] req_release_time = '0, req_process_time = '0, req_due_time = '0;
   logic req_due_present = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [MACH_W-1:0] rsp_machine_id;
   logic [ID_W-1:0] rsp_job_id_out;
   logic [START_W-1:0] rsp_start_time;
   logic [TARD_W-1:0] rsp_job_tardiness;
   logic [TOTAL_W-1:0] rsp_total_tardiness;
   logic rsp_last;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   parallel_machine_atc_dispatch_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  wt_tab [32];
   logic [15:0] rel_tab [32];
   logic [15:0] proc_tab [32];
   logic [15:0] due_tab [1024];
   bit          due_ok [1024];
   bit          loaded [32];
   logic [5:0]  cfg_jobs = 6'd32;
   logic [3:0]  cfg_machs = 4'd1;
   logic [7:0]  cfg_k = 8'd32;

   dispatch_type dispatches[$];
   row_type plan[$];
   int errors = 0;
   int cycles = 0;
   int idle_pct = 0, stall_pct = 0;
   bit hold_req = 0;
   int hold_left = 0;

   initial begin
      foreach (due_ok[i]) due_ok[i] = 0;
      foreach (loaded[i]) loaded[i] = 0;
   end

   function automatic longint unsigned atc_exp(int unsigned xq);
      longint unsigned e;
      e = 65536;
      if (xq > XQ_CLIP) xq = XQ_CLIP;
      for (int i = 0; i < 13; i++)
         if (xq[i]) e = (e * EXP_C[i] + 32768) >> 16;
      return (e > 65535) ? 65535 : e;
   endfunction

   function automatic void dispatch_all();
      int unsigned n, m, kp, mach, best;
      longint unsigned sum_p, t, st, fin, late, tard, total, a, pj, ba, bp, q;
      longint unsigned free_t [8];
      longint slack;
      int unsigned xq;
      bit done [32];
      bit have;
      dispatch_type d;
      n = (cfg_jobs == 0) ? 1 : cfg_jobs;
      if (n > 32) n = 32;
      m = (cfg_machs == 0) ? 1 : cfg_machs;
      if (m > 8) m = 8;
      kp = (cfg_k == 0) ? 1 : cfg_k;
      sum_p = 0;
      for (int j = 0; j < n; j++) sum_p += proc_tab[j];
      if (sum_p == 0) sum_p = 1;
      foreach (free_t[i]) free_t[i] = 0;
      foreach (done[i]) done[i] = 0;
      total = 0;
      for (int s = 0; s < n; s++) begin
         mach = 0;
         for (int k = 1; k < m; k++) if (free_t[k] < free_t[mach]) mach = k;
         t = free_t[mach];
         have = 0; best = 0; ba = 0; bp = 1;
         for (int j = 0; j < n; j++) begin
            if (done[j]) continue;
            a = 0;
            pj = proc_tab[j];
            for (int k = 0; k < n; k++) begin
               if (!due_ok[j*32+k]) continue;
               slack = longint'(due_tab[j*32+k]) - longint'(pj) + longint'(rel_tab[j])
                       - longint'(t);
               xq = 0;
               if (slack > 0) begin
                  q = (longint'(slack) * 16 * n * 256) / (kp * sum_p);
                  xq = (q > XQ_CLIP) ? XQ_CLIP : 32'(q);
               end
               a += wt_tab[k] * atc_exp(xq);
            end
            if (!have || a * bp > ba * pj) begin
               have = 1; best = j; ba = a; bp = pj;
            end
         end
         st = (rel_tab[best] > t) ? rel_tab[best] : t;
         fin = st + proc_tab[best];
         late = 0;
         for (int k = 0; k < n; k++)
            if (due_ok[best*32+k] && fin > due_tab[best*32+k]) late += fin - due_tab[best*32+k];
         tard = late * wt_tab[best];
         done[best] = 1;
         free_t[mach] = (fin > 24'hFFFFFF) ? 24'hFFFFFF : fin;
         total += tard;
         if (total > 48'hFFFFFFFFFFFF) total = 48'hFFFFFFFFFFFF;
         d.mach = MACH_W'(mach); d.job = ID_W'(best); d.start = START_W'(st);
         d.tard = TARD_W'(tard); d.total = TOTAL_W'(total);
         d.last = (s + 1 == n);
         dispatches.push_back(d);
      end
   endfunction

   function automatic void absorb(order_type o);
      case (o.cmd)
         CMD_LOAD_JOB: begin
            wt_tab[o.jid] = o.wgt;
            rel_tab[o.jid] = o.rel;
            proc_tab[o.jid] = (o.proc_t == 0) ? 16'd1 : o.proc_t;
            loaded[o.jid] = 1;
         end
         CMD_LOAD_DUE: begin
            due_tab[{o.jid, o.slot}] = o.due;
            due_ok[{o.jid, o.slot}] = o.pres;
         end
         CMD_RUN: dispatch_all();
         default: ;
      endcase
   endfunction

   task automatic put(order_type o);
      if ($urandom_range(99) < idle_pct)
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_valid <= 0;
         end
      @(negedge clock);
      req_valid <= 1;
      req_cmd <= o.cmd;
      req_job_id <= o.jid;
      req_due_slot <= o.slot;
      req_weight <= o.wgt;
      req_release_time <= o.rel;
      req_process_time <= o.proc_t;
      req_due_time <= o.due;
      req_due_present <= o.pres;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb(o);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 0;
      wait (dispatches.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      case (idx)
         CSR_JOB_COUNT:  cfg_jobs = val[5:0];
         CSR_MACH_COUNT: cfg_machs = val[3:0];
         CSR_LOOK_AHEAD: cfg_k = val;
         default: ;
      endcase
   endtask

   function automatic order_type mk_order(cmd_type c, int j, int s, int w, int r, int p,
                                          int d, int pr);
      order_type o;
      o.cmd = c; o.jid = ID_W'(j); o.slot = ID_W'(s); o.wgt = WGT_W'(w);
      o.rel = TIME_W'(r); o.proc_t = TIME_W'(p); o.due = TIME_W'(d);
      o.pres = pr[0];
      return o;
   endfunction

   function automatic order_type rand_order(cmd_type c);
      return mk_order(c, $urandom_range(31), $urandom_range(31), $urandom_range(255),
         $urandom_range(65535), ($urandom_range(9) == 0) ? 0 : $urandom_range(65535),
         $urandom_range(65535), $urandom_range(1));
   endfunction

   function automatic void add_row(bit is_csr, logic [1:0] idx, logic [7:0] val,
                                   order_type o);
      row_type r;
      r.is_csr = is_csr; r.idx = idx; r.val = val; r.o = o; r.exp_on = 0;
      plan.push_back(r);
   endfunction

   function automatic void add_exp(int mach, int job, int st, longint tard, longint total);
      plan[$].exp_on = 1;
      plan[$].e = '{MACH_W'(mach), ID_W'(job), START_W'(st), TARD_W'(tard),
                    TOTAL_W'(total), 1'b1};
   endfunction

   task automatic job_phase(int n, int m, int k, int count, bit pressure, bit pause);
      order_type o;
      bit held;
      held = 0;
      settle();
      csr_write(CSR_JOB_COUNT, CSR_DATA_W'(n));
      csr_write(CSR_MACH_COUNT, CSR_DATA_W'(m));
      csr_write(CSR_LOOK_AHEAD, CSR_DATA_W'(k));
      for (int i = 0; i <= count; i++) begin
         int r;
         r = (i == count) ? 99 : $urandom_range(99);
         if (pause && i == count / 2) settle();
         if (r < 40) begin
            o = rand_order(CMD_LOAD_JOB);
            if (r < 32) o.jid = ID_W'($urandom_range(n - 1));
            put(o);
         end else if (r < 80) begin
            o = rand_order(CMD_LOAD_DUE);
            if (r < 72) o.jid = ID_W'($urandom_range(n - 1));
            if (r < 60) o.slot = ID_W'($urandom_range(n - 1));
            put(o);
         end else if (r < 86) begin
            put(rand_order(CMD_NOP));
         end else begin
            for (int j = 0; j < n; j++)
               if (!loaded[j]) begin
                  o = rand_order(CMD_LOAD_JOB);
                  o.jid = ID_W'(j);
                  put(o);
               end
            if (pressure && !held) begin
               hold_req = 1;
               held = 1;
            end
            put(rand_order(CMD_RUN));
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = 4000;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      dispatch_type x;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dispatches.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: job %0d", rsp_job_id_out);
         end else begin
            x = dispatches.pop_front();
            if (rsp_machine_id !== x.mach || rsp_job_id_out !== x.job ||
                rsp_start_time !== x.start || rsp_job_tardiness !== x.tard ||
                rsp_total_tardiness !== x.total || rsp_last !== x.last) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch exp m%0d j%0d s%0d t%0d tot%0d l%0d ",
                            "got m%0d j%0d s%0d t%0d tot%0d l%0d"},
                     x.mach, x.job, x.start, x.tard, x.total, x.last, rsp_machine_id,
                     rsp_job_id_out, rsp_start_time, rsp_job_tardiness, rsp_total_tardiness,
                     rsp_last);
            end
         end
      end
   end

   initial begin
      order_type z;
      z = mk_order(CMD_NOP, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, CSR_JOB_COUNT, 1, z);
      add_row(1, CSR_MACH_COUNT, 1, z);
      add_row(0, 0, 0, mk_order(CMD_LOAD_JOB, 0, 0, 255, 100, 0, 0, 0));
      add_row(0, 0, 0, mk_order(CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_exp(0, 0, 100, 0, 0);
      add_row(0, 0, 0, mk_order(CMD_LOAD_DUE, 0, 0, 0, 0, 0, 50, 1));
      add_row(0, 0, 0, mk_order(CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_exp(0, 0, 100, 13005, 13005);
      add_row(0, 0, 0, mk_order(CMD_NOP, 31, 31, 255, 65535, 65535, 65535, 1));
      add_row(0, 0, 0, mk_order(CMD_LOAD_JOB, 31, 31, 0, 65535, 65535, 0, 0));
      add_row(0, 0, 0, mk_order(CMD_LOAD_DUE, 31, 31, 0, 0, 0, 65535, 0));
      add_row(0, 0, 0, mk_order(CMD_LOAD_JOB, 1, 0, 1, 0, 1, 0, 0));
      add_row(0, 0, 0, mk_order(CMD_LOAD_JOB, 2, 0, 128, 0, 300, 0, 0));
      add_row(0, 0, 0, mk_order(CMD_LOAD_JOB, 3, 0, 7, 20, 65535, 0, 0));
      add_row(0, 0, 0, mk_order(CMD_LOAD_DUE, 1, 2, 0, 0, 0, 0, 1));
      add_row(0, 0, 0, mk_order(CMD_LOAD_DUE, 2, 1, 0, 0, 0, 65535, 1));
      add_row(0, 0, 0, mk_order(CMD_LOAD_DUE, 3, 3, 0, 0, 0, 10, 1));
      add_row(1, CSR_JOB_COUNT, 4, z);
      add_row(1, CSR_MACH_COUNT, 8, z);
      add_row(1, CSR_LOOK_AHEAD, 1, z);
      add_row(0, 0, 0, mk_order(CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_row(1, CSR_LOOK_AHEAD, 255, z);
      add_row(1, CSR_MACH_COUNT, 0, z);
      add_row(0, 0, 0, mk_order(CMD_RUN, 0, 0, 0, 0, 0, 0, 0));
      add_row(1, CSR_JOB_COUNT, 0, z);
      add_row(0, 0, 0, mk_order(CMD_RUN, 0, 0, 0, 0, 0, 0, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            csr_write(plan[i].idx, plan[i].val);
         end else begin
            put(plan[i].o);
            if (plan[i].exp_on) begin
               void'(dispatches.pop_back());
               dispatches.push_back(plan[i].e);
            end
         end
      end

      for (int md = 0; md < 4; md++) begin
         idle_pct = (md == 1) ? 71 : (md == 3) ? 36 : 0;
         stall_pct = (md == 2) ? 71 : (md == 3) ? 36 : 0;
         job_phase($urandom_range(2, 6), $urandom_range(1, 8), $urandom_range(255), 12,
                   md == 1, md == 2);
      end

      idle_pct = 0;
      stall_pct = 0;
      settle();
      csr_write(CSR_JOB_COUNT, 8'd63);
      csr_write(CSR_MACH_COUNT, 8'd15);
      csr_write(CSR_LOOK_AHEAD, 8'd0);
      for (int j = 0; j < 32; j++) begin
         z = rand_order(CMD_LOAD_JOB);
         z.jid = ID_W'(j);
         put(z);
      end
      put(rand_order(CMD_RUN));

      @(negedge clock);
      req_valid <= 0;
      wait (dispatches.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
